// ===== rtl/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// Probe response classifier package
// Shared types and protocol constants for the probe response classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package prc_pkg;

	typedef enum logic [1:0] {
		VERDICT_OPEN    = 2'd0,
		VERDICT_REJECT  = 2'd1,
		VERDICT_UNKNOWN = 2'd2
	} verdict_t;

	localparam logic [7:0] PROTO_ICMP       = 8'd1;
	localparam logic [7:0] PROTO_TCP        = 8'd6;
	localparam logic [7:0] ICMP_UNREACHABLE = 8'd3;
	localparam int         ICMP_MIN_BYTES   = 8;
	localparam int         TCP_MIN_BYTES    = 20;
	localparam int         TCP_FLAGS_REL    = 13;
	localparam int         TTL_INDEX        = 8;
	localparam int         PROTO_INDEX      = 9;
	localparam int         SRC_ADDR_FIRST   = 12;
	localparam int         SRC_ADDR_LAST    = 15;
	localparam int         FLAG_RST_BIT     = 2;
	localparam int         FLAG_SYN_BIT     = 1;
	localparam int         FLAG_ACK_BIT     = 4;

	typedef struct packed {
		logic [5:0]  header_offset;
		logic [7:0]  ip_protocol;
		logic [7:0]  ttl;
		logic [31:0] source_addr;
		logic [7:0]  icmp_type;
		logic [15:0] tcp_source_port;
		logic [15:0] tcp_dest_port;
		logic [7:0]  tcp_flags;
	} pkt_info_t;

endpackage

`default_nettype wire

// ===== rtl/prc_capture.sv =====
// ----------------------------------------------------------------------------
// Probe response classifier header capture
// Holds the byte count and the captured header fields of the packet in
// progress, and gives their values after the current byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_capture #(
	parameter int MAX_PACKET_BYTES = 4096
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   take,
	input  wire logic                                   clear,
	input  wire logic [7:0]                             packet_byte,
	output prc_pkg::pkt_info_t                          info_next,
	output logic [$clog2(MAX_PACKET_BYTES + 1) - 1:0]   count_next
);
	import prc_pkg::*;

	localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
	localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_PACKET_BYTES);

	pkt_info_t     info_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] off;
	logic          in_buffer;

	always_comb begin
		info_next  = info_q;
		count_next = count_q;
		in_buffer  = count_q < MAX_COUNT;
		off        = CW'(info_q.header_offset);
		if (in_buffer) begin
			if (count_q == '0) begin
				info_next.header_offset = {packet_byte[3:0], 2'b00};
				off = CW'({packet_byte[3:0], 2'b00});
			end
			if (count_q == CW'(TTL_INDEX)) begin
				info_next.ttl = packet_byte;
			end else if (count_q == CW'(PROTO_INDEX)) begin
				info_next.ip_protocol = packet_byte;
			end else if (count_q >= CW'(SRC_ADDR_FIRST) && count_q <= CW'(SRC_ADDR_LAST)) begin
				info_next.source_addr = {info_q.source_addr[23:0], packet_byte};
			end
			if (count_q == off) begin
				info_next.icmp_type = packet_byte;
				info_next.tcp_source_port[15:8] = packet_byte;
			end else if (count_q == off + CW'(1)) begin
				info_next.tcp_source_port[7:0] = packet_byte;
			end else if (count_q == off + CW'(2)) begin
				info_next.tcp_dest_port[15:8] = packet_byte;
			end else if (count_q == off + CW'(3)) begin
				info_next.tcp_dest_port[7:0] = packet_byte;
			end else if (count_q == off + CW'(TCP_FLAGS_REL)) begin
				info_next.tcp_flags = packet_byte;
			end
			count_next = count_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_q  <= '0;
			count_q <= '0;
		end else if (take) begin
			if (clear) begin
				info_q  <= '0;
				count_q <= '0;
			end else begin
				info_q  <= info_next;
				count_q <= count_next;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/prc_verdict.sv =====
// ----------------------------------------------------------------------------
// Probe response classifier verdict logic
// Classifies a complete packet from its captured fields and byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_verdict #(
	parameter int MAX_PACKET_BYTES = 4096
) (
	input  wire prc_pkg::pkt_info_t                     info,
	input  wire logic [$clog2(MAX_PACKET_BYTES + 1) - 1:0] byte_count,
	input  wire logic [31:0]                            expected_source_addr,
	input  wire logic [15:0]                            expected_remote_port,
	input  wire logic [15:0]                            expected_local_port,
	output prc_pkg::verdict_t                           verdict,
	output logic [7:0]                                  received_ttl
);
	import prc_pkg::*;

	localparam int CW = $clog2(MAX_PACKET_BYTES + 1);

	logic icmp_hit;
	logic tcp_match;
	logic syn_ack;
	logic rst;

	always_comb begin
		icmp_hit = (info.ip_protocol == PROTO_ICMP)
			&& (byte_count >= CW'(info.header_offset) + CW'(ICMP_MIN_BYTES))
			&& (info.icmp_type == ICMP_UNREACHABLE);
		tcp_match = (info.ip_protocol == PROTO_TCP)
			&& (info.source_addr == expected_source_addr)
			&& (byte_count >= CW'(info.header_offset) + CW'(TCP_MIN_BYTES))
			&& (info.tcp_dest_port == expected_local_port)
			&& (info.tcp_source_port == expected_remote_port);
		syn_ack = info.tcp_flags[FLAG_SYN_BIT] && info.tcp_flags[FLAG_ACK_BIT];
		rst     = info.tcp_flags[FLAG_RST_BIT];

		verdict      = VERDICT_UNKNOWN;
		received_ttl = 8'd0;
		if (icmp_hit) begin
			verdict      = VERDICT_REJECT;
			received_ttl = info.ttl;
		end else if (tcp_match && syn_ack) begin
			verdict      = VERDICT_OPEN;
			received_ttl = info.ttl;
		end else if (tcp_match && rst) begin
			verdict      = VERDICT_REJECT;
			received_ttl = info.ttl;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/probe_response_classifier.sv =====
// ----------------------------------------------------------------------------
// Probe response classifier
// Classifies a received IPv4 probe response, one byte per transfer, as open,
// reject or unknown, and reports the received TTL.
// ----------------------------------------------------------------------------
// Each accepted byte passes an input register, then the header capture and
// verdict logic, and one result is written to an output register on the byte
// marked last. A byte is accepted every cycle unless the input side stalls;
// the result of a last byte passes the input register and then the output
// register. The input side stalls only while a result waits in the output
// register and the next registered byte is itself a last byte.
// Bytes beyond MAX_PACKET_BYTES are dropped, and the length checks use the
// saturated count. The expected address and ports are sampled with each byte
// and those given with the last byte are used.
// ----------------------------------------------------------------------------
`default_nettype none

module probe_response_classifier #(
	parameter int MAX_PACKET_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  packet_byte,
	input  wire logic        last_byte,
	input  wire logic [31:0] expected_source_addr,
	input  wire logic [15:0] expected_remote_port,
	input  wire logic [15:0] expected_local_port,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       verdict,
	output logic [7:0]       received_ttl
);
	import prc_pkg::*;

	localparam int CW = $clog2(MAX_PACKET_BYTES + 1);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [31:0] addr_s1;
	logic [15:0] remote_s1;
	logic [15:0] local_s1;

	logic        advance;
	logic        result_load;
	pkt_info_t   info_next;
	logic [CW-1:0] count_next;
	verdict_t    verdict_d;
	logic [7:0]  ttl_d;

	logic        out_valid_q;
	verdict_t    verdict_q;
	logic [7:0]  ttl_q;

	assign advance     = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign result_load = advance && last_s1;
	assign in_ready    = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1   <= packet_byte;
			last_s1   <= last_byte;
			addr_s1   <= expected_source_addr;
			remote_s1 <= expected_remote_port;
			local_s1  <= expected_local_port;
		end
	end

	prc_capture #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (advance),
		.clear      (last_s1),
		.packet_byte(byte_s1),
		.info_next  (info_next),
		.count_next (count_next)
	);

	prc_verdict #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_verdict (
		.info                (info_next),
		.byte_count          (count_next),
		.expected_source_addr(addr_s1),
		.expected_remote_port(remote_s1),
		.expected_local_port (local_s1),
		.verdict             (verdict_d),
		.received_ttl        (ttl_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			verdict_q <= verdict_d;
			ttl_q     <= ttl_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign verdict      = verdict_q;
	assign received_ttl = ttl_q;

endmodule

`default_nettype wire

// ===== verif/tb_probe_response_classifier.sv =====
// ----------------------------------------------------------------------------
// Probe response classifier testbench
// Sends IPv4 packets one byte per transfer and checks every verdict and TTL
// against a cycle-free model of the classifier. Packets are mostly well
// formed ICMP and TCP responses with random content, mixed with broken,
// short and noise packets, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_probe_response_classifier;
	import prc_pkg::*;

	localparam int PKT_BUF_BYTES = 4096;
	localparam int RANDOM_ITEMS = 1300;
	localparam logic [7:0] MASK_SYN = 8'(1 << FLAG_SYN_BIT);
	localparam logic [7:0] MASK_ACK = 8'(1 << FLAG_ACK_BIT);
	localparam logic [7:0] MASK_RST = 8'(1 << FLAG_RST_BIT);
	localparam logic [7:0] MASK_SYN_ACK = MASK_SYN | MASK_ACK;

	typedef struct {
		logic [7:0]  data;
		logic        lst;
		logic [31:0] addr;
		logic [15:0] rport;
		logic [15:0] lport;
	} byte_item_t;

	typedef struct {
		verdict_t   verdict;
		logic [7:0] ttl;
	} probe_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  packet_byte = '0;
	logic        last_byte = 1'b0;
	logic [31:0] expected_source_addr = '0;
	logic [15:0] expected_remote_port = '0;
	logic [15:0] expected_local_port = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  verdict;
	logic [7:0]  received_ttl;

	byte_item_t    pending_bytes[$];
	probe_result_t expected_results[$];
	logic [7:0]    pkt_bytes[$];
	int            mismatches = 0;

	// Model state of the packet in progress.
	logic [12:0] seen_count = '0;
	logic [5:0]  hdr_len = '0;
	logic [7:0]  cap_proto = '0;
	logic [7:0]  cap_ttl = '0;
	logic [31:0] cap_src = '0;
	logic [7:0]  cap_icmp = '0;
	logic [15:0] cap_sport = '0;
	logic [15:0] cap_dport = '0;
	logic [7:0]  cap_flags = '0;

	probe_response_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.packet_byte(packet_byte),
		.last_byte(last_byte),
		.expected_source_addr(expected_source_addr),
		.expected_remote_port(expected_remote_port),
		.expected_local_port(expected_local_port),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.verdict(verdict),
		.received_ttl(received_ttl)
	);

	always #2 clk = ~clk;

	task automatic absorb_byte(input logic [7:0] b, input logic lst, input logic [31:0] ea,
			input logic [15:0] erp, input logic [15:0] elp);
		int idx;
		int rel;
		int len;
		probe_result_t res;
		idx = seen_count;
		if (idx < PKT_BUF_BYTES) begin
			if (idx == 0)
				hdr_len = {b[3:0], 2'b00};
			if (idx == TTL_INDEX)
				cap_ttl = b;
			else if (idx == PROTO_INDEX)
				cap_proto = b;
			else if (idx >= SRC_ADDR_FIRST && idx <= SRC_ADDR_LAST)
				cap_src = {cap_src[23:0], b};
			if (idx >= int'(hdr_len)) begin
				rel = idx - int'(hdr_len);
				case (rel)
					0: begin
						cap_icmp = b;
						cap_sport[15:8] = b;
					end
					1: cap_sport[7:0] = b;
					2: cap_dport[15:8] = b;
					3: cap_dport[7:0] = b;
					TCP_FLAGS_REL: cap_flags = b;
					default: ;
				endcase
			end
			seen_count = 13'(idx + 1);
		end
		if (lst) begin
			len = seen_count;
			res.verdict = VERDICT_UNKNOWN;
			res.ttl = '0;
			if (cap_proto == PROTO_ICMP && len >= int'(hdr_len) + ICMP_MIN_BYTES
					&& cap_icmp == ICMP_UNREACHABLE) begin
				res.verdict = VERDICT_REJECT;
				res.ttl = cap_ttl;
			end else if (cap_proto == PROTO_TCP && cap_src == ea
					&& len >= int'(hdr_len) + TCP_MIN_BYTES
					&& cap_dport == elp && cap_sport == erp) begin
				if (cap_flags[FLAG_SYN_BIT] && cap_flags[FLAG_ACK_BIT]) begin
					res.verdict = VERDICT_OPEN;
					res.ttl = cap_ttl;
				end else if (cap_flags[FLAG_RST_BIT]) begin
					res.verdict = VERDICT_REJECT;
					res.ttl = cap_ttl;
				end
			end
			expected_results.push_back(res);
			seen_count = '0;
			hdr_len = '0;
			cap_proto = '0;
			cap_ttl = '0;
			cap_src = '0;
			cap_icmp = '0;
			cap_sport = '0;
			cap_dport = '0;
			cap_flags = '0;
		end
	endtask

	function automatic void poke(input int idx, input logic [7:0] val);
		if (idx < pkt_bytes.size())
			pkt_bytes[idx] = val;
	endfunction

	task automatic build_packet(input int ihl, input int plen, input logic [7:0] ttl,
			input logic [7:0] proto, input logic [31:0] src, input logic [7:0] ttype,
			input logic [15:0] sp, input logic [15:0] dp, input logic [7:0] flg);
		int off;
		pkt_bytes.delete();
		for (int i = 0; i < plen; i++)
			pkt_bytes.push_back(8'($urandom));
		off = ihl * 4;
		// Transport fields go first so that the IP header wins where they overlap.
		if (proto == PROTO_ICMP)
			poke(off, ttype);
		else
			poke(off, sp[15:8]);
		poke(off + 1, sp[7:0]);
		poke(off + 2, dp[15:8]);
		poke(off + 3, dp[7:0]);
		poke(off + TCP_FLAGS_REL, flg);
		poke(0, {($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'h4, 4'(ihl)});
		poke(TTL_INDEX, ttl);
		poke(PROTO_INDEX, proto);
		for (int i = 0; i < 4; i++)
			poke(SRC_ADDR_FIRST + i, src[31 - 8 * i -: 8]);
	endtask

	task automatic send_packet(input logic [31:0] ea, input logic [15:0] erp,
			input logic [15:0] elp, input bit scramble);
		byte_item_t it;
		for (int i = 0; i < pkt_bytes.size(); i++) begin
			it.data = pkt_bytes[i];
			it.lst = (i == pkt_bytes.size() - 1);
			it.addr = ea;
			it.rport = erp;
			it.lport = elp;
			if (scramble && !it.lst && $urandom_range(0, 3) == 0) begin
				it.addr = $urandom;
				it.rport = 16'($urandom);
				it.lport = 16'($urandom);
			end
			pending_bytes.push_back(it);
		end
	endtask

	// Sender: bursts of transfers separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		logic v;
		byte_item_t it;
		if (arst_n) begin
			v = in_valid;
			if (in_valid && in_ready) begin
				absorb_byte(packet_byte, last_byte, expected_source_addr,
					expected_remote_port, expected_local_port);
				v = 1'b0;
			end
			if (!v) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_bytes.size() > 0) begin
					it = pending_bytes.pop_front();
					v = 1'b1;
					packet_byte <= it.data;
					last_byte <= it.lst;
					expected_source_addr <= it.addr;
					expected_remote_port <= it.rport;
					expected_local_port <= it.lport;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			in_valid <= v;
		end
	end

	// Receiver: stall pattern that switches between several modes.
	int stall_mode = 0;
	int mode_left = 0;
	int cycle_count = 0;

	always @(posedge clk) begin
		logic rdy;
		if (arst_n) begin
			cycle_count++;
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(64, 300);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: rdy = 1'b1;
				1: rdy = $urandom_range(0, 1);
				2: rdy = ($urandom_range(0, 7) == 0);
				default: rdy = (cycle_count % 11) < 4;
			endcase
			out_ready <= rdy;
		end
	end

	always @(posedge clk) begin
		probe_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: verdict %0d, received_ttl %0d", verdict,
					received_ttl);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (verdict !== want.verdict) begin
					$error("verdict: expected %0d, actual %0d", want.verdict, verdict);
					mismatches++;
				end
				if (received_ttl !== want.ttl) begin
					$error("received_ttl: expected %0d, actual %0d", want.ttl, received_ttl);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int queued;
		int kind;
		int ihl;
		int off;
		int plen;
		logic [31:0] src;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [7:0] flg;
		logic [31:0] ea;
		logic [15:0] erp;
		logic [15:0] elp;

		// Directed packets: single bytes at both extremes, then a TCP packet with a
		// zero header length, whose SYN+ACK flag byte is overwritten by the source address.
		pkt_bytes.delete();
		pkt_bytes.push_back(8'h00);
		send_packet(32'h0, 16'h0, 16'h0, 1'b0);
		pkt_bytes.delete();
		pkt_bytes.push_back(8'hFF);
		send_packet(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		build_packet(0, 20, 8'hFF, PROTO_TCP, 32'hC0A8_0112, 8'h00, 16'h4001, 16'hFFFF,
			MASK_SYN_ACK);
		pkt_bytes[0] = 8'h40;
		src = {pkt_bytes[12], pkt_bytes[13], pkt_bytes[14], pkt_bytes[15]};
		send_packet(src, {pkt_bytes[0], pkt_bytes[1]}, {pkt_bytes[2], pkt_bytes[3]}, 1'b0);

		queued = 0;
		while (queued < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			ihl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 5;
			off = ihl * 4;
			src = $urandom;
			sp = 16'($urandom);
			dp = 16'($urandom);
			case ($urandom_range(0, 5))
				0: flg = MASK_SYN_ACK;
				1: flg = MASK_RST;
				2: flg = MASK_SYN_ACK | MASK_RST;
				3: flg = MASK_SYN;
				4: flg = MASK_ACK;
				default: flg = 8'($urandom);
			endcase
			flg = flg | (8'($urandom) & ~(MASK_SYN_ACK | MASK_RST));
			ea = src;
			erp = sp;
			elp = dp;
			case (kind)
				0, 1: begin
					plen = off + $urandom_range(5, 12);
					build_packet(ihl, plen, 8'($urandom), PROTO_ICMP, src, ICMP_UNREACHABLE,
						sp, dp, flg);
				end
				2: begin
					plen = off + $urandom_range(6, 30);
					build_packet(ihl, plen, 8'($urandom), PROTO_ICMP, src, 8'($urandom),
						sp, dp, flg);
				end
				6: begin
					plen = off + $urandom_range(20, 30);
					build_packet(ihl, plen, 8'($urandom), PROTO_TCP, src, 8'h0, sp, dp, flg);
					case ($urandom_range(0, 2))
						0: ea[$urandom_range(0, 31)] ^= 1'b1;
						1: erp[$urandom_range(0, 15)] ^= 1'b1;
						default: elp[$urandom_range(0, 15)] ^= 1'b1;
					endcase
				end
				7: begin
					plen = off + $urandom_range(18, 30);
					build_packet(ihl, plen, 8'($urandom), ($urandom_range(0, 1) == 0) ?
						8'($urandom) : PROTO_ICMP, src, 8'($urandom), sp, dp, flg);
				end
				8: begin
					plen = $urandom_range(1, 80);
					pkt_bytes.delete();
					for (int i = 0; i < plen; i++)
						pkt_bytes.push_back(8'($urandom));
					ea = $urandom;
				end
				default: begin
					plen = off + (($urandom_range(0, 3) == 0) ? $urandom_range(16, 22) :
						$urandom_range(20, 40));
					build_packet(ihl, plen, 8'($urandom), PROTO_TCP, src, 8'h0, sp, dp, flg);
				end
			endcase
			send_packet(ea, erp, elp, $urandom_range(0, 7) == 0);
			queued += pkt_bytes.size();
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
